[src/lps_pkg.sv]
// types and constants shared by the laser power sequencer modules
`default_nettype none

package lps_pkg;

    localparam int STATE_W   = 3;
    localparam int MODE_W    = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    localparam logic [STATE_W-1:0] ST_OFF       = 3'd0;
    localparam logic [STATE_W-1:0] ST_COOLER_UP = 3'd1;
    localparam logic [STATE_W-1:0] ST_DIODE_UP  = 3'd2;
    localparam logic [STATE_W-1:0] ST_READY     = 3'd3;
    localparam logic [STATE_W-1:0] ST_FIRING    = 3'd4;
    localparam logic [STATE_W-1:0] ST_FAULT     = 3'd5;

    localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OPERATE  = 2'd1;

    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_FORCE = 1'b1;

    // input transaction, lowest bit is fault_active
    typedef struct packed {
        logic               cmd;
        logic [STATE_W-1:0] forced_state;
        logic               clear_request;
        logic               trigger_in;
        logic               permit_in;
        logic               diode_rail_ready;
        logic               cooler_ready;
        logic               fault_active;
    } in_item_t;

    localparam int IN_FIELDS_W = $bits(in_item_t) - 1;

    // result transaction, lowest bits are current_state
    typedef struct packed {
        logic               setpoint_clamp;
        logic               emission_wanted;
        logic [MODE_W-1:0]  diode_mode;
        logic               diode_power_on;
        logic               cooler_power_on;
        logic [STATE_W-1:0] current_state;
    } out_item_t;

    localparam int OUT_FIELDS_W = $bits(out_item_t);

endpackage

`default_nettype wire

[src/lps_next_state.sv]
// transition rules of the sequencer for step and force transactions
`default_nettype none

module lps_next_state (
    input  wire  lps_pkg::in_item_t                item,
    input  wire  logic [lps_pkg::STATE_W-1:0]      state,
    output logic [lps_pkg::STATE_W-1:0]            state_next
);
    import lps_pkg::*;

    logic go;

    assign go = item.permit_in & item.trigger_in;

    always_comb begin
        state_next = state;
        if (item.cmd == CMD_FORCE) begin
            if (item.forced_state > ST_FAULT) begin
                state_next = ST_FAULT;
            end else begin
                state_next = item.forced_state;
            end
        end else if (item.fault_active) begin
            state_next = ST_FAULT;
        end else begin
            case (state)
                ST_OFF:       state_next = ST_COOLER_UP;
                ST_COOLER_UP: state_next = item.cooler_ready ? ST_DIODE_UP : ST_COOLER_UP;
                ST_DIODE_UP:  state_next = item.diode_rail_ready ? ST_READY : ST_DIODE_UP;
                ST_READY:     state_next = go ? ST_FIRING : ST_READY;
                ST_FIRING:    state_next = go ? ST_FIRING : ST_READY;
                default:      state_next = item.clear_request ? ST_OFF : ST_FAULT;
            endcase
        end
    end

endmodule

`default_nettype wire

[src/lps_decode.sv]
// output decode of the sequencer state
`default_nettype none

module lps_decode (
    input  wire  logic [lps_pkg::STATE_W-1:0] state,
    input  wire  logic [lps_pkg::MODE_W-1:0]  ready_mode,
    output lps_pkg::out_item_t                result
);
    import lps_pkg::*;

    always_comb begin
        result                 = '0;
        result.current_state   = state;
        result.diode_mode      = MODE_SHUTDOWN;
        result.setpoint_clamp  = 1'b1;
        case (state)
            ST_COOLER_UP: begin
                result.cooler_power_on = 1'b1;
            end
            ST_DIODE_UP: begin
                result.cooler_power_on = 1'b1;
                result.diode_power_on  = 1'b1;
            end
            ST_READY: begin
                result.cooler_power_on = 1'b1;
                result.diode_power_on  = 1'b1;
                result.diode_mode      = ready_mode;
            end
            ST_FIRING: begin
                result.cooler_power_on = 1'b1;
                result.diode_power_on  = 1'b1;
                result.diode_mode      = MODE_OPERATE;
                result.emission_wanted = 1'b1;
                result.setpoint_clamp  = 1'b0;
            end
            default: begin
                result.cooler_power_on = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/laser_power_sequencer.sv]
// laser power sequencer top level
//
// Power-up and firing interlock for a laser diode with a cooler.
// Input channel s_*: one transaction per step (tuser 0) or force (tuser 1),
// carrying the fault, rail ready, permit, trigger and clear conditions and
// the state to load on force. Output channel m_*: one transaction per input
// transaction with the new state and the decoded supply enables, diode mode,
// emission request and setpoint clamp.
// cfg_wr_en / cfg_wr_data write the diode mode used in the ready state;
// write it only while no transaction is in flight.
// The result passes through the input register, then the transition and decode
// logic into the output register, which drives m_tvalid. The state register
// updates in the same cycle as the output register, so one transaction is
// taken per cycle while m_tready stays high.
// When m_tready is low the output register holds and the input register
// still takes one more transaction; s_tready drops only when both are full.
// Synchronous reset (aresetn low) empties both registers, sets the state to
// off and the ready diode mode to shutdown.
`default_nettype none

module laser_power_sequencer (
    input  wire  logic                              aclk,
    input  wire  logic                              aresetn,
    input  wire  logic                              cfg_wr_en,
    input  wire  logic [lps_pkg::MODE_W-1:0]        cfg_wr_data,
    input  wire  logic                              s_tvalid,
    output logic                                    s_tready,
    // fault_active, cooler_ready, diode_rail_ready, permit_in, trigger_in,
    // clear_request, forced_state[2:0], zero fill
    input  wire  logic [lps_pkg::S_TDATA_W-1:0]     s_tdata,
    // cmd
    input  wire  logic                              s_tuser,
    output logic                                    m_tvalid,
    input  wire  logic                              m_tready,
    // current_state[2:0], cooler_power_on, diode_power_on, diode_mode[1:0],
    // emission_wanted, setpoint_clamp, zero fill
    output logic [lps_pkg::M_TDATA_W-1:0]           m_tdata
);
    import lps_pkg::*;

    logic                 in_valid_reg;
    in_item_t             in_item_reg;
    logic                 out_valid_reg;
    out_item_t            out_item_reg;
    logic [STATE_W-1:0]   state_reg;
    logic [MODE_W-1:0]    ready_mode_reg;

    logic                 out_free;
    logic                 advance;
    logic                 in_take;
    logic [STATE_W-1:0]   state_next;
    out_item_t            result;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    lps_next_state u_next_state (
        .item       (in_item_reg),
        .state      (state_reg),
        .state_next (state_next)
    );

    lps_decode u_decode (
        .state      (state_next),
        .ready_mode (ready_mode_reg),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= ST_OFF;
            ready_mode_reg <= MODE_SHUTDOWN;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                ready_mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg <= {s_tuser, s_tdata[IN_FIELDS_W-1:0]};
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_FIELDS_W){1'b0}}, out_item_reg};

endmodule

`default_nettype wire

[src/lps_checker.sv]
// port-level checks for the laser power sequencer and their bind
`default_nettype none

module lps_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata
);
    import lps_pkg::*;

    // output transaction held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a force transaction shows up at the output, clamped to fault, when the receiver keeps up
    a_force: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == CMD_FORCE && m_tready) ##1 m_tready
        |=> m_tvalid && m_tdata[2:0] ==
            (($past(s_tdata[8:6], 2) > ST_FAULT) ? ST_FAULT : $past(s_tdata[8:6], 2)))
        else $error("forced state not reported");

    // emission only in firing, with setpoints unclamped
    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7] == (m_tdata[2:0] == ST_FIRING))
                     && (m_tdata[8] == !m_tdata[7]) && (m_tdata[15:9] == 7'd0))
        else $error("emission decode inconsistent");

endmodule

bind laser_power_sequencer lps_checker u_lps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
